/* rtl/sti_pkg.sv */
// Package for the sine tone injector: default sizes, register indexes, fixed constants.
`default_nettype none
package sti_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_PHASE_STEP   = 2'd0;
    localparam t_cfg_idx REG_PHASE_OFFSET = 2'd1;
    localparam t_cfg_idx REG_AMPLITUDE    = 2'd2;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage
`default_nettype wire

/* rtl/sine_tone_injector_core.sv */
// Sine tone injector: adds a table-driven sine tone to a stream of signed samples.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word per sample:
//   i_sample_in and i_first_of_series. Output channel (o_out_valid /
//   i_out_ready) carries o_sample_out and o_saturated, one word per input.
//   Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data):
//   index 0 phase step, 1 phase offset, 2 amplitude; other indexes ignored.
//   Write configuration only while the pipeline is empty.
// Timing:
//   Four-stage pipeline: phase/address, quarter-wave ROM read, amplitude
//   multiply, add and saturate. Throughput is one word per cycle while the output
//   word is taken, set by the single phase add per sample.
// Reset:
//   Clears the phase accumulator, step and offset, sets amplitude to full
//   scale and empties the pipeline.
// Stall:
//   When the output word is not taken, all stages hold and o_in_ready drops
//   in the same cycle; nothing is lost or repeated.
`default_nettype none
module sine_tone_injector_core #(
    parameter int PHASE_BITS      = sti_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_BITS     = sti_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = sti_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire sti_pkg::t_cfg_idx              i_cfg_index,
    input  wire logic [sti_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_sample_in,
    input  wire logic                           i_first_of_series,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_sample_out,
    output logic                                o_saturated
);
    import sti_pkg::*;

    localparam int PW     = PHASE_BITS;
    localparam int SW     = SAMPLE_BITS;
    localparam int MAG_W  = SW - 1;
    localparam int TB     = SINE_TABLE_BITS;
    localparam int TAB_N  = 1 << TB;
    localparam int PROD_W = 2 * MAG_W;
    localparam int SUM_W  = SW + 2;

    localparam logic [63:0] FULL_SCALE = (64'd1 << (SW - 1)) - 64'd1;
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(FULL_SCALE);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (SW - 2));

    typedef logic [MAG_W-1:0] t_tab [TAB_N];

    function automatic logic [63:0] sine_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k[0]) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        return (sum < 0) ? 64'd0 : unsigned'(sum);
    endfunction

    function automatic t_tab build_tab();
        t_tab        tab;
        logic [63:0] ang;
        logic [63:0] v;
        for (int i = 0; i < TAB_N; i++) begin
            ang = (64'(2 * i + 1) * HALF_PI_Q30) >> (TB + 1);
            v   = (sine_q30(ang) * FULL_SCALE + (64'd1 << 29)) >> 30;
            if (v > FULL_SCALE) begin
                v = FULL_SCALE;
            end
            tab[i] = MAG_W'(v);
        end
        return tab;
    endfunction

    localparam t_tab SINE_TAB = build_tab();

    // config registers
    logic [CFG_DATA_W-1:0] r_phase_step;
    logic [CFG_DATA_W-1:0] r_phase_offset;
    logic [MAG_W-1:0]      r_amplitude;
    logic [PW-1:0]         r_phase_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= '0;
            r_phase_offset <= '0;
            r_amplitude    <= MAG_W'(FULL_SCALE);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PHASE_STEP:   r_phase_step   <= i_cfg_data;
                REG_PHASE_OFFSET: r_phase_offset <= i_cfg_data;
                REG_AMPLITUDE:    r_amplitude    <= i_cfg_data[MAG_W-1:0];
                default: ;
            endcase
        end
    end

    logic [PW-1:0] w_step;
    logic [PW-1:0] w_offset;
    logic [PW-1:0] w_start;
    logic [PW-1:0] w_phase;
    logic          w_en;
    logic          w_accept;

    assign w_step   = PW'({{PW{1'b0}}, r_phase_step});
    assign w_offset = PW'({{PW{1'b0}}, r_phase_offset});
    assign w_start  = w_offset + (w_step >> 1);
    assign w_phase  = i_first_of_series ? w_start : r_phase_acc;

    // pipeline state
    logic                  r_v1, r_v2, r_v3, r_v4;
    logic [TB-1:0]         r1_idx;
    logic                  r1_neg, r2_neg, r3_neg;
    logic signed [SW-1:0]  r1_smp, r2_smp, r3_smp;
    logic [MAG_W-1:0]      r2_mag;
    logic [PROD_W-1:0]     r3_prod;
    logic signed [SW-1:0]  r_sample_out;
    logic                  r_saturated;

    assign w_en     = !r_v4 || i_out_ready;
    assign w_accept = i_in_valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc <= '0;
        end else if (w_accept) begin
            r_phase_acc <= w_phase + w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // stage 1: quadrant and table address, mirrored in odd quadrants
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_idx <= w_phase[PW-2] ? ~w_phase[PW-3 -: TB] : w_phase[PW-3 -: TB];
            r1_neg <= w_phase[PW-1];
            r1_smp <= i_sample_in;
        end
    end

    // stage 2: quarter-wave ROM
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_mag <= SINE_TAB[r1_idx];
            r2_neg <= r1_neg;
            r2_smp <= r1_smp;
        end
    end

    // stage 3: amplitude scaling
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_prod <= PROD_W'(r_amplitude) * PROD_W'(r2_mag);
            r3_neg  <= r2_neg;
            r3_smp  <= r2_smp;
        end
    end

    // stage 4: round, add, saturate
    logic [PROD_W-1:0]       w_rounded;
    logic signed [SUM_W-1:0] w_tone;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SW-1:0]    n_sample_out;
    logic                    n_saturated;

    assign w_rounded = (r3_prod + ROUND_HALF) >> (SW - 1);
    assign w_tone    = signed'(SUM_W'(w_rounded));
    assign w_sum     = r3_neg ? (SUM_W'(r3_smp) - w_tone) : (SUM_W'(r3_smp) + w_tone);

    always_comb begin
        n_saturated  = 1'b0;
        n_sample_out = w_sum[SW-1:0];
        if (w_sum > SUM_MAX) begin
            n_sample_out = SUM_MAX[SW-1:0];
            n_saturated  = 1'b1;
        end else if (w_sum < SUM_MIN) begin
            n_sample_out = SUM_MIN[SW-1:0];
            n_saturated  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sample_out <= n_sample_out;
            r_saturated  <= n_saturated;
        end
    end

    assign o_in_ready   = w_en;
    assign o_out_valid  = r_v4;
    assign o_sample_out = r_sample_out;
    assign o_saturated  = r_saturated;

`ifndef SYNTH
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_sample_out == SUM_MAX[SW-1:0] || o_sample_out == SUM_MIN[SW-1:0]))
        else $error("saturation flag without clipped value");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    a_restart_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_first_of_series && !i_cfg_we) |=>
            (r_phase_acc == $past(w_start + w_step)))
        else $error("phase restart wrong");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_v4 && !i_out_ready) |=> (r_v3 && r_v4))
        else $error("pipeline word dropped during stall");
`endif

endmodule
`default_nettype wire

/* bench/sti_tone_checker.sv */
// Checker for the sine tone injector: mirrors config and phase, predicts each output word, compares.
module sti_tone_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire sti_pkg::t_cfg_idx              i_cfg_index,
    input  wire logic [sti_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_ready,
    input  wire logic signed [15:0]             i_sample_in,
    input  wire logic                           i_first_of_series,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic signed [15:0]             i_sample_out,
    input  wire logic                           i_saturated,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import sti_pkg::*;

    localparam int TAB_N = 1 << SINE_TABLE_BITS_DEF;
    localparam logic [63:0] FULL_SCALE = 64'd32767;

    typedef struct packed {
        logic signed [15:0] sum;
        logic               clip;
    } t_tone_word;

    logic [15:0] sine_quarter [0:TAB_N-1];
    t_tone_word  expected_sums [$];

    logic [31:0] step_reg;
    logic [31:0] offset_reg;
    logic [14:0] amp_reg;
    logic [31:0] phase_acc;
    int          fails = 0;

    // Q30 Taylor series of sin, cut after the x^15 term
    function automatic logic [63:0] taylor_sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc -= longint'(term);
            end else begin
                acc += longint'(term);
            end
        end
        return (acc < 0) ? 64'd0 : 64'(acc);
    endfunction

    initial begin
        logic [63:0] ang;
        logic [63:0] v;
        for (int i = 0; i < TAB_N; i++) begin
            ang = (64'(2 * i + 1) * HALF_PI_Q30) >> (SINE_TABLE_BITS_DEF + 1);
            v   = (taylor_sine_q30(ang) * FULL_SCALE + (64'd1 << 29)) >> 30;
            if (v > FULL_SCALE) begin
                v = FULL_SCALE;
            end
            sine_quarter[i] = v[15:0];
        end
    end

    function automatic t_tone_word predict_tone_sum(input logic signed [15:0] smp,
                                                    input logic [31:0] ph,
                                                    input logic [14:0] amp);
        logic [1:0]  quad;
        logic [9:0]  idx;
        logic [15:0] mag;
        logic [31:0] tone;
        int          sum;
        t_tone_word  w;
        quad = ph[31:30];
        idx  = ph[29:20];
        mag  = quad[0] ? sine_quarter[TAB_N - 1 - int'(idx)] : sine_quarter[idx];
        tone = (32'(amp) * 32'(mag) + 32'd16384) >> 15;
        sum  = quad[1] ? int'(smp) - int'(tone) : int'(smp) + int'(tone);
        w.clip = 1'b0;
        if (sum > 32767) begin
            sum    = 32767;
            w.clip = 1'b1;
        end
        if (sum < -32768) begin
            sum    = -32768;
            w.clip = 1'b1;
        end
        w.sum = 16'(sum);
        return w;
    endfunction

    always @(posedge i_clk) begin
        logic [31:0] ph;
        t_tone_word  want;
        if (!i_rst_n) begin
            step_reg   = '0;
            offset_reg = '0;
            amp_reg    = 15'h7fff;
            phase_acc  = '0;
            expected_sums.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PHASE_STEP: begin
                        step_reg = i_cfg_data[31:0];
                    end
                    REG_PHASE_OFFSET: begin
                        offset_reg = i_cfg_data[31:0];
                    end
                    REG_AMPLITUDE: begin
                        amp_reg = i_cfg_data[14:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                ph = i_first_of_series ? offset_reg + (step_reg >> 1) : phase_acc;
                phase_acc = ph + step_reg;
                expected_sums.push_back(predict_tone_sum(i_sample_in, ph, amp_reg));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_sums.size() == 0) begin
                    if (fails < 10) begin
                        $display("unexpected word: sample_out=%0d saturated=%0b",
                                 i_sample_out, i_saturated);
                    end
                    fails++;
                end else begin
                    want = expected_sums.pop_front();
                    if (i_sample_out !== want.sum || i_saturated !== want.clip) begin
                        if (fails < 10) begin
                            $display("mismatch: expected %0d %0b, got %0d %0b",
                                     want.sum, want.clip, i_sample_out, i_saturated);
                        end
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_sums.size();
    end

endmodule

/* bench/tb_sine_tone_injector_core.sv */
// Testbench top for the sine tone injector: clock, reset, stimulus, config phases and verdict.
module tb_sine_tone_injector_core;
    import sti_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam t_cfg_idx REG_SPARE = t_cfg_idx'(3);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    t_cfg_idx              cfg_index = REG_PHASE_STEP;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [15:0]    sample_in = '0;
    logic                  first_of_series = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [15:0]    sample_out;
    logic                  saturated;

    int fail_count;
    int words_pending;
    int cycles = 0;
    int stall_left = 0;
    bit idle_on = 1'b1;

    sine_tone_injector_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_sample_in       (sample_in),
        .i_first_of_series (first_of_series),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_sample_out      (sample_out),
        .o_saturated       (saturated)
    );

    sti_tone_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_sample_in       (sample_in),
        .i_first_of_series (first_of_series),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_sample_out      (sample_out),
        .i_saturated       (saturated),
        .o_fail_count      (fail_count),
        .o_pending         (words_pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output back-pressure in random bursts while idle_on is set
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic signed [15:0] s, input logic f);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid        <= 1'b1;
        sample_in       <= s;
        first_of_series <= f;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (words_pending != 0);
    endtask

    task automatic write_setting(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [31:0] step, input logic [31:0] offset,
                                  input logic [31:0] amp_word, input bit spare);
        write_setting(REG_PHASE_STEP, step);
        write_setting(REG_PHASE_OFFSET, offset);
        if (spare) begin
            write_setting(REG_SPARE, $urandom);
        end
        write_setting(REG_AMPLITUDE, amp_word);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return 16'(int'($urandom_range(0, 15)) - 8);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        logic [31:0] step;
        logic [31:0] offset;
        logic [31:0] amp_word;
        int          n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: zero step and offset, full amplitude
        send_word(16'sh7fff, 1'b1);
        send_word(-16'sh8000, 1'b0);
        send_word(16'sh0000, 1'b0);
        send_word(-16'sh0001, 1'b0);
        end_burst();

        // odd quarter-turn step, amplitude word with high bits set, spare index ignored
        apply_settings(32'h4000_0001, 32'hC000_0000, 32'hFFFF_FFFF, 1'b1);
        send_word(-16'sh8000, 1'b1);
        send_word(16'sh7fff, 1'b0);
        send_word(-16'sh8000, 1'b0);
        send_word(16'sh7fff, 1'b0);
        send_word(16'sh7d00, 1'b0);
        send_word(-16'sh7d00, 1'b0);
        send_word(16'sh0000, 1'b1);
        send_word(16'sh0000, 1'b0);
        end_burst();

        apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        send_word(16'sh7fff, 1'b1);
        send_word(-16'sh8000, 1'b0);
        send_word(16'sh0005, 1'b0);
        send_word(-16'sh0005, 1'b1);
        end_burst();

        apply_settings(32'h0000_0000, 32'h4000_0000, 32'hFFFF_4000, 1'b0);
        send_word(16'sh5555, 1'b1);
        send_word(-16'sh5556, 1'b0);
        send_word(16'sh7fff, 1'b0);
        end_burst();

        for (int p = 0; p < 12; p++) begin
            idle_on = (p != 5) && (p != 11);
            case ($urandom_range(0, 5))
                0: step = 32'h0000_0000;
                1: step = 32'hFFFF_FFFF;
                2: step = $urandom_range(1, 1 << 22);
                default: step = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0: offset = 32'h0000_0000;
                1: offset = 32'hFFFF_FFFF;
                default: offset = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0: amp_word = {16'($urandom_range(0, 65535)), 16'h0000} & 32'hFFFF_8000;
                1: amp_word = {16'($urandom_range(0, 65535)), 16'h7fff} | 32'h0000_7fff;
                default: amp_word = $urandom;
            endcase
            apply_settings(step, offset, amp_word, $urandom_range(0, 2) == 0);
            n = 125;
            for (int k = 0; k < n; k++) begin
                send_word(rand_sample(), (k == 0) || ($urandom_range(0, 15) == 0));
            end
            end_burst();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/sti_pkg.sv
rtl/sine_tone_injector_core.sv
bench/sti_tone_checker.sv
bench/tb_sine_tone_injector_core.sv
